FILE: design/hrdsp_pkg.sv
// ----------------------------------------------------------------------------
// hrdsp_pkg
// Shared types and codes for the report descriptor size parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrdsp_pkg;

	// item types in header bits 3:2
	localparam logic [1:0] TYPE_MAIN   = 2'd0;
	localparam logic [1:0] TYPE_GLOBAL = 2'd1;

	// main item tags
	localparam logic [3:0] TAG_INPUT   = 4'd8;
	localparam logic [3:0] TAG_OUTPUT  = 4'd9;
	localparam logic [3:0] TAG_FEATURE = 4'd11;

	// global item tags
	localparam logic [3:0] TAG_REPORT_SIZE  = 4'd7;
	localparam logic [3:0] TAG_REPORT_ID    = 4'd8;
	localparam logic [3:0] TAG_REPORT_COUNT = 4'd9;

	// report kinds
	localparam logic [1:0] KIND_INPUT   = 2'd0;
	localparam logic [1:0] KIND_OUTPUT  = 2'd1;
	localparam logic [1:0] KIND_FEATURE = 2'd2;

	localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;
	localparam logic [7:0] BYTE_SIZE_MAX  = 8'd255;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic take;
		logic apply;
		logic emit;
		logic clear;
	} dp_cmd_t;

	typedef struct packed {
		logic emit_last;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: design/hrdsp_ctrl.sv
// ----------------------------------------------------------------------------
// hrdsp_ctrl
// Sequencer: takes a word, applies the finished item, then walks the table
// out after the final word and clears the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module hrdsp_ctrl
	import hrdsp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic     final_byte,
	output logic          busy,
	output dp_cmd_t       cmd,
	input  wire dp_stat_t stat
);

	ctrl_state_t state_q, state_d;
	logic        final_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.take) begin
				final_q <= final_byte;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		busy      = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.take = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.apply = 1'b1;
				state_d   = final_q ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (stat.emit_last) begin
					cmd.clear = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: design/hrdsp_datapath.sv
// ----------------------------------------------------------------------------
// hrdsp_datapath
// Item assembly, global state, report table with parallel match, and the
// registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hrdsp_datapath
	import hrdsp_pkg::*;
#(
	parameter int REPORT_SLOTS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dp_cmd_t    cmd,
	output dp_stat_t        stat,
	input  wire logic [7:0] desc_byte,
	output logic            result_valid,
	output logic [7:0]      entry_id,
	output logic [1:0]      entry_kind,
	output logic [7:0]      byte_size,
	output logic            last_entry
);

	localparam int IDX_W = (REPORT_SLOTS > 1) ? $clog2(REPORT_SLOTS) : 1;
	localparam int CNT_W = $clog2(REPORT_SLOTS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(REPORT_SLOTS);

	// item assembly
	logic [7:0]  header_q;
	logic [2:0]  left_q;
	logic [1:0]  idx_q;
	logic [31:0] value_q;
	logic        complete_q;
	logic [2:0]  size_n;

	// globals
	logic [7:0]  cur_id_q;
	logic [31:0] cur_bits_q;
	logic [31:0] cur_count_q;
	logic [31:0] prod_q;

	// report table
	logic [7:0]       tbl_id_q    [REPORT_SLOTS];
	logic [1:0]       tbl_kind_q  [REPORT_SLOTS];
	logic [31:0]      tbl_total_q [REPORT_SLOTS];
	logic [CNT_W-1:0] used_q;
	logic [IDX_W-1:0] emit_idx_q;

	logic [1:0]              item_type;
	logic [3:0]              item_tag;
	logic                    is_report;
	logic [1:0]              item_kind;
	logic [REPORT_SLOTS-1:0] hit;
	logic [IDX_W-1:0]        hit_idx;
	logic                    any_hit;
	logic                    has_room;

	logic [31:0] rd_total;
	logic [29:0] rd_bytes;
	logic [7:0]  rd_size;

	assign size_n    = (desc_byte[1:0] == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, desc_byte[1:0]};
	assign item_type = header_q[3:2];
	assign item_tag  = header_q[7:4];
	assign has_room  = (used_q < CNT_MAX);

	always_comb begin
		is_report = 1'b1;
		item_kind = KIND_INPUT;
		unique case (item_tag)
			TAG_INPUT:   item_kind = KIND_INPUT;
			TAG_OUTPUT:  item_kind = KIND_OUTPUT;
			TAG_FEATURE: item_kind = KIND_FEATURE;
			default:     is_report = 1'b0;
		endcase
	end

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < REPORT_SLOTS; i++) begin
			hit[i] = (CNT_W'(i) < used_q) && (tbl_id_q[i] == cur_id_q) &&
				(tbl_kind_q[i] == item_kind);
			if (hit[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
		any_hit = |hit;
	end

	// item assembly and globals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q    <= '0;
			left_q      <= '0;
			idx_q       <= '0;
			value_q     <= '0;
			complete_q  <= 1'b0;
			cur_id_q    <= '0;
			cur_bits_q  <= '0;
			cur_count_q <= '0;
		end else if (cmd.clear) begin
			header_q    <= '0;
			left_q      <= '0;
			idx_q       <= '0;
			value_q     <= '0;
			complete_q  <= 1'b0;
			cur_id_q    <= '0;
			cur_bits_q  <= '0;
			cur_count_q <= '0;
		end else if (cmd.take) begin
			if (left_q == 3'd0) begin
				header_q   <= desc_byte;
				value_q    <= '0;
				idx_q      <= '0;
				left_q     <= size_n;
				complete_q <= (size_n == 3'd0);
			end else begin
				value_q    <= value_q | ({24'd0, desc_byte} << {idx_q, 3'b000});
				idx_q      <= idx_q + 2'd1;
				left_q     <= left_q - 3'd1;
				complete_q <= (left_q == 3'd1);
			end
		end else if (cmd.apply && complete_q && item_type == TYPE_GLOBAL) begin
			priority case (item_tag)
				TAG_REPORT_ID:    cur_id_q    <= value_q[7:0];
				TAG_REPORT_SIZE:  cur_bits_q  <= value_q;
				TAG_REPORT_COUNT: cur_count_q <= value_q;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 32'(cur_bits_q * cur_count_q);
	end

	// table contents
	always_ff @(posedge clk) begin
		if (cmd.apply && complete_q && item_type == TYPE_MAIN && is_report) begin
			if (any_hit) begin
				tbl_total_q[hit_idx] <= tbl_total_q[hit_idx] + prod_q;
			end else if (has_room) begin
				tbl_id_q[used_q[IDX_W-1:0]]    <= cur_id_q;
				tbl_kind_q[used_q[IDX_W-1:0]]  <= item_kind;
				tbl_total_q[used_q[IDX_W-1:0]] <= prod_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			emit_idx_q <= '0;
		end else if (cmd.clear) begin
			used_q     <= '0;
			emit_idx_q <= '0;
		end else begin
			if (cmd.apply && complete_q && item_type == TYPE_MAIN && is_report &&
					!any_hit && has_room) begin
				used_q <= used_q + CNT_W'(1);
			end
			if (cmd.emit) begin
				emit_idx_q <= emit_idx_q + IDX_W'(1);
			end
		end
	end

	// result stage
	assign stat.emit_last = (used_q == '0) ||
		(CNT_W'(emit_idx_q) == (used_q - CNT_W'(1)));

	assign rd_total = tbl_total_q[emit_idx_q];
	assign rd_bytes = {1'b0, rd_total[31:3]} + {29'd0, |rd_total[2:0]};
	assign rd_size  = (rd_bytes > 30'(BYTE_SIZE_MAX)) ? BYTE_SIZE_MAX : rd_bytes[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			last_entry <= stat.emit_last;
			if (used_q == '0) begin
				entry_id   <= '0;
				entry_kind <= KIND_INPUT;
				byte_size  <= '0;
			end else begin
				entry_id   <= tbl_id_q[emit_idx_q];
				entry_kind <= tbl_kind_q[emit_idx_q];
				byte_size  <= (tbl_kind_q[emit_idx_q] == KIND_INPUT) ? rd_size : 8'd0;
			end
		end
	end

	// checks
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_MAX)
		else $error("table fill beyond capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (used_q == '0) && (left_q == 3'd0))
		else $error("parser not cleared after a run");

	a_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit))
		else $error("duplicate table entry");

	a_emit_not_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !cmd.take && !cmd.apply)
		else $error("word taken during table output");

endmodule

`default_nettype wire

FILE: design/hid_report_descriptor_size_parser.sv
// ----------------------------------------------------------------------------
// hid_report_descriptor_size_parser
// Parses report descriptor words into a table of report IDs and sizes and
// emits the table after the final word.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------
//   word in  | start & !busy          | desc_byte, final_byte
//   result   | result_valid (1 cycle) | entry_id, entry_kind, byte_size,
//            |                        | last_entry
//
// each word is taken, then the finished item is applied through the table match
// and the accumulate of the registered product
// after the final word the table goes out one entry a cycle (at least one)
// and the parser clears itself; busy stays high until then
// reset: asynchronous, empty table, awaiting an item header
// results cannot be held off by the receiver
// ----------------------------------------------------------------------------
`default_nettype none

module hid_report_descriptor_size_parser
	import hrdsp_pkg::*;
#(
	parameter int REPORT_SLOTS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [7:0] desc_byte,
	input  wire logic       final_byte,
	output logic            result_valid,
	output logic [7:0]      entry_id,
	output logic [1:0]      entry_kind,
	output logic [7:0]      byte_size,
	output logic            last_entry
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	hrdsp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.final_byte (final_byte),
		.busy       (busy),
		.cmd        (cmd),
		.stat       (stat)
	);

	hrdsp_datapath #(
		.REPORT_SLOTS (REPORT_SLOTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.desc_byte    (desc_byte),
		.result_valid (result_valid),
		.entry_id     (entry_id),
		.entry_kind   (entry_kind),
		.byte_size    (byte_size),
		.last_entry   (last_entry)
	);

endmodule

`default_nettype wire

FILE: dv/hid_size_table_checker.sv
// ----------------------------------------------------------------------------
// hid_size_table_checker
// Watches the word and result channels of the report descriptor size parser.
// It rebuilds the report table from every accepted word and checks each
// emitted table row field by field against the oldest row still due.
// ----------------------------------------------------------------------------
module hid_size_table_checker
	import hrdsp_pkg::*;
#(
	parameter int REPORT_SLOTS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [7:0] desc_byte,
	input  logic       final_byte,
	input  logic       result_valid,
	input  logic [7:0] entry_id,
	input  logic [1:0] entry_kind,
	input  logic [7:0] byte_size,
	input  logic       last_entry,
	output int         errors,
	output int         pending,
	output int         rows_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] id;
		logic [1:0] kind;
		logic [7:0] size;
		logic       last;
	} table_row_t;

	table_row_t rows_due[$];

	logic [7:0]  item_hdr;
	logic [2:0]  bytes_left;
	logic [1:0]  byte_idx;
	logic [31:0] item_val;
	logic [7:0]  cur_id;
	logic [31:0] cur_bits;
	logic [31:0] cur_count;
	logic [7:0]  tab_id   [REPORT_SLOTS];
	logic [1:0]  tab_kind [REPORT_SLOTS];
	logic [31:0] tab_bits [REPORT_SLOTS];
	int          tab_used;

	function automatic void clear_parse();
		item_hdr = '0;
		bytes_left = '0;
		byte_idx = '0;
		item_val = '0;
		cur_id = '0;
		cur_bits = '0;
		cur_count = '0;
		tab_used = 0;
		for (int i = 0; i < REPORT_SLOTS; i++) begin
			tab_id[i] = '0;
			tab_kind[i] = '0;
			tab_bits[i] = '0;
		end
	endfunction

	// a finished item updates the globals or accumulates into the table
	function automatic void fold_item();
		logic [1:0] ty;
		logic [3:0] tg;
		logic [1:0] k;
		int slot;
		ty = item_hdr[3:2];
		tg = item_hdr[7:4];
		if (ty == TYPE_GLOBAL) begin
			case (tg)
				TAG_REPORT_ID:    cur_id = item_val[7:0];
				TAG_REPORT_SIZE:  cur_bits = item_val;
				TAG_REPORT_COUNT: cur_count = item_val;
				default: ;
			endcase
			return;
		end
		if (ty != TYPE_MAIN)
			return;
		case (tg)
			TAG_INPUT:   k = KIND_INPUT;
			TAG_OUTPUT:  k = KIND_OUTPUT;
			TAG_FEATURE: k = KIND_FEATURE;
			default:     return;
		endcase
		slot = -1;
		for (int i = 0; i < tab_used; i++)
			if (slot < 0 && tab_id[i] == cur_id && tab_kind[i] == k)
				slot = i;
		if (slot < 0) begin
			if (tab_used >= REPORT_SLOTS)
				return;
			slot = tab_used;
			tab_id[slot] = cur_id;
			tab_kind[slot] = k;
			tab_bits[slot] = '0;
			tab_used++;
		end
		tab_bits[slot] = tab_bits[slot] + cur_bits * cur_count;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		table_row_t want;
		table_row_t got;
		logic [32:0] rounded;
		logic [29:0] nbytes;
		if (!arst_n) begin
			clear_parse();
			rows_due.delete();
			errors = 0;
			rows_checked = 0;
		end else begin
			if (result_valid === 1'b1) begin
				rows_checked++;
				got = {entry_id, entry_kind, byte_size, last_entry};
				if (rows_due.size() == 0) begin
					$error("unexpected row: id %0d kind %0d size %0d last %0d",
						got.id, got.kind, got.size, got.last);
					errors++;
				end else begin
					want = rows_due.pop_front();
					if (got.id !== want.id) begin
						$error("entry_id: expected %0d, got %0d", want.id, got.id);
						errors++;
					end
					if (got.kind !== want.kind) begin
						$error("entry_kind: expected %0d, got %0d", want.kind, got.kind);
						errors++;
					end
					if (got.size !== want.size) begin
						$error("byte_size: expected %0d, got %0d", want.size, got.size);
						errors++;
					end
					if (got.last !== want.last) begin
						$error("last_entry: expected %0d, got %0d", want.last, got.last);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				if (bytes_left == 0) begin
					item_hdr = desc_byte;
					bytes_left = (desc_byte[1:0] == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, desc_byte[1:0]};
					item_val = '0;
					byte_idx = '0;
					if (bytes_left == 0)
						fold_item();
				end else begin
					item_val = item_val | (32'(desc_byte) << (8 * byte_idx));
					byte_idx = byte_idx + 2'd1;
					bytes_left = bytes_left - 3'd1;
					if (bytes_left == 0)
						fold_item();
				end
				if (final_byte) begin
					if (tab_used == 0) begin
						rows_due.push_back('{id: 8'd0, kind: KIND_INPUT, size: 8'd0, last: 1'b1});
					end else begin
						for (int i = 0; i < tab_used; i++) begin
							rounded = {1'b0, tab_bits[i]} + 33'd7;
							nbytes = rounded[32:3];
							want.id = tab_id[i];
							want.kind = tab_kind[i];
							want.size = (nbytes > 30'(BYTE_SIZE_MAX)) ? BYTE_SIZE_MAX : nbytes[7:0];
							if (tab_kind[i] != KIND_INPUT)
								want.size = '0;
							want.last = (i == tab_used - 1);
							rows_due.push_back(want);
						end
					end
					clear_parse();
				end
			end
		end
		pending = rows_due.size();
	end

endmodule

FILE: dv/hid_report_descriptor_size_parser_test.sv
// ----------------------------------------------------------------------------
// hid_report_descriptor_size_parser_test
// Feeds report descriptors word by word into the size parser: a few directed
// descriptors, then random ones built mostly from well-formed items with
// random content, some cut off, some plain noise, with random input gaps.
// A checker beside the block predicts and compares every table row.
// ----------------------------------------------------------------------------
module hid_report_descriptor_size_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hrdsp_pkg::*;

	localparam int REPORT_SLOTS = 8;

	localparam logic [1:0] TYPE_LOCAL    = 2'd2;
	localparam logic [1:0] TYPE_RESERVED = 2'd3;
	localparam logic [3:0] TAG_UNUSED    = 4'd0;
	localparam logic [3:0] TAG_LONG      = 4'd15;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [7:0] desc_byte;
	logic       final_byte;
	logic       result_valid;
	logic [7:0] entry_id;
	logic [1:0] entry_kind;
	logic [7:0] byte_size;
	logic       last_entry;

	int errors;
	int pending;
	int rows_checked;
	int words_sent = 0;
	int descs_sent = 0;
	bit idling = 1'b1;

	logic [7:0] desc_q[$];

	hid_report_descriptor_size_parser #(
		.REPORT_SLOTS(REPORT_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.desc_byte(desc_byte),
		.final_byte(final_byte),
		.result_valid(result_valid),
		.entry_id(entry_id),
		.entry_kind(entry_kind),
		.byte_size(byte_size),
		.last_entry(last_entry)
	);

	hid_size_table_checker #(
		.REPORT_SLOTS(REPORT_SLOTS)
	) table_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.desc_byte(desc_byte),
		.final_byte(final_byte),
		.result_valid(result_valid),
		.entry_id(entry_id),
		.entry_kind(entry_kind),
		.byte_size(byte_size),
		.last_entry(last_entry),
		.errors(errors),
		.pending(pending),
		.rows_checked(rows_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (!idling)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int fit_len(logic [31:0] v);
		int nb;
		nb = (v > 32'hFFFF) ? 4 : (v > 32'hFF) ? 2 : (v != 0) ? 1 : 0;
		if ($urandom_range(0, 3) == 0)
			nb = 4;
		return nb;
	endfunction

	// entered and left at a falling edge
	task automatic send_word(input logic [7:0] b, input logic fin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		desc_byte <= b;
		final_byte <= fin;
		do @(posedge clk); while (busy);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_descriptor();
		foreach (desc_q[i])
			send_word(desc_q[i], i == desc_q.size() - 1);
		descs_sent++;
		desc_q.delete();
	endtask

	task automatic put_head(input logic [1:0] ty, input logic [3:0] tg, input int nb);
		desc_q.push_back({tg, ty, (nb == 4) ? SIZE_CODE_FOUR : 2'(nb)});
	endtask

	task automatic put_item(input logic [1:0] ty, input logic [3:0] tg, input logic [31:0] v,
			input int nb);
		put_head(ty, tg, nb);
		for (int i = 0; i < nb; i++)
			desc_q.push_back(v[8*i +: 8]);
	endtask

	task automatic put_field(input logic [3:0] tg);
		logic [31:0] v;
		if ($urandom_range(0, 9) == 0)
			v = $urandom();
		else if (tg == TAG_REPORT_SIZE)
			v = $urandom_range(0, 16);
		else
			v = $urandom_range(0, 64);
		put_item(TYPE_GLOBAL, tg, v, fit_len(v));
	endtask

	task automatic build_random_descriptor();
		int mode;
		int n_items;
		int r;
		int nb;
		logic [7:0] hdr;
		logic [31:0] v;
		mode = $urandom_range(0, 9);
		n_items = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 10);
		if (mode == 0) begin
			repeat ($urandom_range(1, 8))
				desc_q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat (n_items) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				v = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 9);
				put_item(TYPE_GLOBAL, TAG_REPORT_ID, v, fit_len(v));
			end else if (r < 30) begin
				put_field(TAG_REPORT_SIZE);
			end else if (r < 42) begin
				put_field(TAG_REPORT_COUNT);
			end else if (r < 88) begin
				if ($urandom_range(0, 1)) begin
					put_field(TAG_REPORT_SIZE);
					put_field(TAG_REPORT_COUNT);
				end
				v = $urandom_range(0, 255);
				case ($urandom_range(0, 2))
					0:       put_item(TYPE_MAIN, TAG_INPUT, v, fit_len(v));
					1:       put_item(TYPE_MAIN, TAG_OUTPUT, v, fit_len(v));
					default: put_item(TYPE_MAIN, TAG_FEATURE, v, fit_len(v));
				endcase
			end else begin
				hdr = 8'($urandom_range(0, 255));
				desc_q.push_back(hdr);
				nb = (hdr[1:0] == SIZE_CODE_FOUR) ? 4 : hdr[1:0];
				repeat (nb)
					desc_q.push_back(8'($urandom_range(0, 255)));
			end
		end
		// cut off: a header whose data never fully arrives
		if (mode == 1) begin
			nb = $urandom_range(1, 4);
			put_head(TYPE_GLOBAL, TAG_REPORT_COUNT, nb);
			repeat ($urandom_range(0, nb - 1))
				desc_q.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		desc_byte = '0;
		final_byte = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table gives the default row
		put_item(TYPE_MAIN, TAG_UNUSED, 32'd0, 0);
		send_descriptor();

		// top report id, one entry of each kind
		put_item(TYPE_GLOBAL, TAG_REPORT_ID, 32'd255, 1);
		put_item(TYPE_GLOBAL, TAG_REPORT_SIZE, 32'd8, 1);
		put_item(TYPE_GLOBAL, TAG_REPORT_COUNT, 32'd3, 1);
		put_item(TYPE_MAIN, TAG_INPUT, 32'd2, 1);
		put_item(TYPE_MAIN, TAG_OUTPUT, 32'd0, 1);
		put_item(TYPE_MAIN, TAG_FEATURE, 32'd0, 1);
		send_descriptor();

		// four-byte value, saturation, ignored items, cut-off last item
		put_item(TYPE_GLOBAL, TAG_REPORT_COUNT, 32'd1, 1);
		put_item(TYPE_GLOBAL, TAG_REPORT_SIZE, 32'hFFFF_FFFF, 4);
		put_item(TYPE_MAIN, TAG_INPUT, 32'd0, 0);
		put_item(TYPE_LOCAL, TAG_UNUSED, 32'd0, 0);
		put_item(TYPE_RESERVED, TAG_UNUSED, 32'd0, 0);
		put_item(TYPE_RESERVED, TAG_LONG, 32'h1234, 2);
		put_head(TYPE_GLOBAL, TAG_REPORT_COUNT, 1);
		send_descriptor();

		while (words_sent < 465) begin
			build_random_descriptor();
			idling = ($urandom_range(0, 3) != 0);
			send_descriptor();
		end
		start <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);

		$display("covered %0d words in %0d descriptors, %0d table rows checked",
			words_sent, descs_sent, rows_checked);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
